// File: rtl/core/ustd_pkg.sv
// Shared types, constants and microcode program for the seconds-to-date converter.
// Used by ustd_datapath and unix_seconds_to_date_unit; no dependencies.

package ustd_pkg;

   // Step counter width
   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   // Divisors for the time-of-day split
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;

   // Reciprocals floor(2^s / d), s = dividend width (32, 17, 12 bits);
   // the estimate is at most one below the true quotient
   localparam logic [15:0] DAY_RECIP  = 16'd49710;
   localparam logic [15:0] HOUR_RECIP = 16'd36;
   localparam logic [15:0] MIN_RECIP  = 16'd68;

   // Year bookkeeping, counted as an offset from 1970
   localparam logic [8:0] DAYS_PER_YEAR  = 9'd365;
   localparam logic [7:0] BASE_YEAR_OFF  = 8'd30;   // 2000
   localparam logic [7:0] LAST_YEAR_OFF  = 8'd129;  // 2099
   localparam logic [1:0] EPOCH_MOD4     = 2'd2;    // 1970 mod 4
   localparam logic [6:0] EPOCH_MOD100   = 7'd70;   // 1970 mod 100
   localparam logic [8:0] EPOCH_MOD400   = 9'd370;  // 1970 mod 400
   localparam logic [6:0] MOD100_LAST    = 7'd99;
   localparam logic [8:0] MOD400_LAST    = 9'd399;
   localparam logic [3:0] LAST_MONTH_IDX = 4'd11;
   localparam logic [3:0] FEB_IDX        = 4'd1;

   // Datapath operations, one per control word
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_DIV_EST,
      OP_DIV_REM,
      OP_DIV_FIX,
      OP_YEAR_STEP,
      OP_MONTH_STEP,
      OP_DONE
   } op_type;

   // Divisor select
   typedef enum logic [1:0] {
      DIV_DAY,
      DIV_HOUR,
      DIV_MIN
   } div_sel_type;

   // Repeat conditions: step stays put while true, else goes to next
   typedef enum logic [2:0] {
      COND_NONE,
      COND_WAIT_REQ,
      COND_YEAR_MORE,
      COND_MONTH_MORE,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      op_type      op;
      div_sel_type div_sel;
      cond_type    cond;
      pc_type      next;
   } ctrl_word_type;

   // Status flags from datapath to sequencer
   typedef struct packed {
      logic year_more;
      logic month_more;
   } status_type;

   typedef struct packed {
      logic [6:0] year_since_2000;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       year_out_of_range;
   } result_type;

   localparam pc_type PC_IDLE = 4'd0;

   // Microcode: load, estimate/remainder/fix per division, year/month loops, done
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type cw;
      begin
         unique case (pc)
            4'd0:  cw = '{OP_LOAD,       DIV_DAY,  COND_WAIT_REQ,   4'd1};
            4'd1:  cw = '{OP_DIV_EST,    DIV_DAY,  COND_NONE,       4'd2};
            4'd2:  cw = '{OP_DIV_REM,    DIV_DAY,  COND_NONE,       4'd3};
            4'd3:  cw = '{OP_DIV_FIX,    DIV_DAY,  COND_NONE,       4'd4};
            4'd4:  cw = '{OP_DIV_EST,    DIV_HOUR, COND_NONE,       4'd5};
            4'd5:  cw = '{OP_DIV_REM,    DIV_HOUR, COND_NONE,       4'd6};
            4'd6:  cw = '{OP_DIV_FIX,    DIV_HOUR, COND_NONE,       4'd7};
            4'd7:  cw = '{OP_DIV_EST,    DIV_MIN,  COND_NONE,       4'd8};
            4'd8:  cw = '{OP_DIV_REM,    DIV_MIN,  COND_NONE,       4'd9};
            4'd9:  cw = '{OP_DIV_FIX,    DIV_MIN,  COND_NONE,       4'd10};
            4'd10: cw = '{OP_YEAR_STEP,  DIV_DAY,  COND_YEAR_MORE,  4'd11};
            4'd11: cw = '{OP_MONTH_STEP, DIV_DAY,  COND_MONTH_MORE, 4'd12};
            4'd12: cw = '{OP_DONE,       DIV_DAY,  COND_WAIT_OUT,   PC_IDLE};
            default: cw = '{OP_LOAD,     DIV_DAY,  COND_WAIT_REQ,   4'd1};
         endcase
         return cw;
      end
   endfunction

   // Month length, February lengthened in leap years
   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      begin
         case (mon) inside
            FEB_IDX:                 len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

// File: rtl/core/ustd_datapath.sv
// Datapath of the seconds-to-date converter: reciprocal-multiply divider,
// year and month reduction. Driven by control words; uses ustd_pkg.

module ustd_datapath (
   input  logic                  clock,
   input  logic [31:0]           req_timestamp,
   input  ustd_pkg::ctrl_word_type ctrl,
   output ustd_pkg::status_type  status,
   output ustd_pkg::result_type  result
);
   import ustd_pkg::*;

   logic [31:0] x_ff;
   logic [15:0] q_ff;
   logic [17:0] r_ff;
   logic [15:0] days_ff;
   logic [7:0]  year_ff;
   logic [1:0]  mod4_ff;
   logic [6:0]  mod100_ff;
   logic [8:0]  mod400_ff;
   logic [3:0]  mon_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;

   logic [16:0] div_val;
   logic [15:0] recip;
   logic [47:0] est_prod;
   logic [15:0] q_est;
   logic [32:0] back_prod;
   logic [32:0] rem_diff;
   logic        fix_up;
   logic [15:0] fix_q;
   logic [17:0] fix_r;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic        year_more;
   logic        month_more;
   logic        out_of_range;
   logic [7:0]  year_rel;

   // Divisor and reciprocal select
   always_comb begin
      case (ctrl.div_sel)
         DIV_HOUR: begin
            div_val = SECS_PER_HOUR;
            recip   = HOUR_RECIP;
         end
         DIV_MIN: begin
            div_val = SECS_PER_MIN;
            recip   = MIN_RECIP;
         end
         default: begin
            div_val = SECS_PER_DAY;
            recip   = DAY_RECIP;
         end
      endcase
   end

   // Quotient estimate: dividend times reciprocal, shifted by dividend width
   assign est_prod = {16'd0, x_ff} * {32'd0, recip};

   always_comb begin
      case (ctrl.div_sel)
         DIV_HOUR: q_est = est_prod[32:17];
         DIV_MIN:  q_est = est_prod[27:12];
         default:  q_est = est_prod[47:32];
      endcase
   end

   // Remainder of the estimate, below twice the divisor
   assign back_prod = {17'd0, q_ff} * {16'd0, div_val};
   assign rem_diff  = {1'b0, x_ff} - back_prod;

   // One correction step
   assign fix_up = (r_ff >= {1'b0, div_val});
   assign fix_q  = q_ff + {15'd0, fix_up};
   assign fix_r  = fix_up ? r_ff - {1'b0, div_val} : r_ff;

   // Gregorian leap rule from running residues
   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign ylen = DAYS_PER_YEAR + {8'd0, leap};
   assign mlen = month_days(mon_ff, leap);

   assign year_more  = (days_ff >= {7'd0, ylen});
   assign month_more = (mon_ff < LAST_MONTH_IDX) && (days_ff >= {11'd0, mlen});

   assign status.year_more  = year_more;
   assign status.month_more = month_more;

   // Register updates per operation
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_LOAD: begin
            x_ff      <= req_timestamp;
            year_ff   <= '0;
            mod4_ff   <= EPOCH_MOD4;
            mod100_ff <= EPOCH_MOD100;
            mod400_ff <= EPOCH_MOD400;
            mon_ff    <= '0;
         end
         OP_DIV_EST: begin
            q_ff <= q_est;
         end
         OP_DIV_REM: begin
            r_ff <= rem_diff[17:0];
         end
         OP_DIV_FIX: begin
            case (ctrl.div_sel)
               DIV_HOUR: begin
                  hour_ff <= fix_q[4:0];
                  x_ff    <= {14'd0, fix_r};
               end
               DIV_MIN: begin
                  minute_ff <= fix_q[5:0];
                  second_ff <= fix_r[5:0];
               end
               default: begin
                  days_ff <= fix_q;
                  x_ff    <= {14'd0, fix_r};
               end
            endcase
         end
         OP_YEAR_STEP: begin
            if (year_more) begin
               days_ff   <= days_ff - {7'd0, ylen};
               year_ff   <= year_ff + 8'd1;
               mod4_ff   <= mod4_ff + 2'd1;
               mod100_ff <= (mod100_ff == MOD100_LAST) ? 7'd0 : mod100_ff + 7'd1;
               mod400_ff <= (mod400_ff == MOD400_LAST) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         OP_MONTH_STEP: begin
            if (month_more) begin
               days_ff <= days_ff - {11'd0, mlen};
               mon_ff  <= mon_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result fields
   assign out_of_range = (year_ff < BASE_YEAR_OFF) || (year_ff > LAST_YEAR_OFF);
   assign year_rel     = year_ff - BASE_YEAR_OFF;

   assign result.year_since_2000   = out_of_range ? 7'd0 : year_rel[6:0];
   assign result.month             = mon_ff + 4'd1;
   assign result.day_of_month      = days_ff[4:0] + 5'd1;
   assign result.hour              = hour_ff;
   assign result.minute            = minute_ff;
   assign result.second            = second_ff;
   assign result.year_out_of_range = out_of_range;

endmodule

// File: rtl/core/unix_seconds_to_date_unit.sv
// Top level of the seconds-to-date converter: microcode sequencer and result register.
// Depends on ustd_pkg and ustd_datapath.
//
// Usage:
//   req_valid/req_stall/req_timestamp carry one item: seconds since 1970-01-01.
//   rsp_valid/rsp_stall and the rsp_ fields carry the calendar date and time.
//   An item is taken when the sequencer sits at its idle step; req_stall is
//   high while one item is being converted and during reset.
//   After acceptance the sequencer runs three divisions of three steps each
//   (estimate, remainder, fix), then the calendar reduction, whose year step
//   repeats once per year since 1970 (0..136) and whose month step repeats
//   once per month index (0..11), each plus one closing pass, and then the
//   finish step. The next item can be taken in the cycle after the result
//   loads; the unit converts one item at a time.
//   The result sits in an output register, so the next item can be accepted
//   while a finished result waits. If the receiver stalls with a result
//   still held, the finish step waits until the register frees up.
//   Synchronous reset returns the sequencer to idle and drops rsp_valid.
//   Years outside 2000..2099 raise rsp_year_out_of_range with year 0.

module unix_seconds_to_date_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_year_since_2000,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic        rsp_year_out_of_range
);
   import ustd_pkg::*;

   pc_type        pc_ff, pc_in;
   ctrl_word_type cw;
   status_type    status;
   result_type    result;
   result_type    rsp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          cond_hit;
   logic          out_load;

   ustd_datapath u_datapath (
      .clock         (clock),
      .req_timestamp (req_timestamp),
      .ctrl          (cw),
      .status        (status),
      .result        (result)
   );

   // Control word fetch
   assign cw = ucode_rom(pc_ff);

   // Repeat condition decode
   always_comb begin
      unique case (cw.cond)
         COND_WAIT_REQ:   cond_hit = !req_valid;
         COND_YEAR_MORE:  cond_hit = status.year_more;
         COND_MONTH_MORE: cond_hit = status.month_more;
         COND_WAIT_OUT:   cond_hit = rsp_valid_ff && rsp_stall;
         default:         cond_hit = 1'b0;
      endcase
   end

   // Step counter: hold while condition true, else follow next field
   assign pc_in = cond_hit ? pc_ff : cw.next;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_stall = reset || (cw.op != OP_LOAD);

   // Result register
   assign out_load = (cw.op == OP_DONE) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_year_since_2000   = rsp_data_ff.year_since_2000;
   assign rsp_month             = rsp_data_ff.month;
   assign rsp_day_of_month      = rsp_data_ff.day_of_month;
   assign rsp_hour              = rsp_data_ff.hour;
   assign rsp_minute            = rsp_data_ff.minute;
   assign rsp_second            = rsp_data_ff.second;
   assign rsp_year_out_of_range = rsp_data_ff.year_out_of_range;

endmodule

// File: rtl/core/ustd_checker.sv
// Port-level checks for unix_seconds_to_date_unit, attached by bind.
// No package dependency.

module ustd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_year_since_2000,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day_of_month,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second,
   input logic        rsp_year_out_of_range
);

   // Stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year_since_2000)
         && $stable(rsp_month) && $stable(rsp_day_of_month) && $stable(rsp_hour)
         && $stable(rsp_minute) && $stable(rsp_second) && $stable(rsp_year_out_of_range))
      else $error("rsp item changed while stalled");

   // One item at a time: busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while conversion in progress");

   // Flagged year reads zero
   a_flag_zero_year: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_year_out_of_range |-> rsp_year_since_2000 == 7'd0)
      else $error("out-of-range year not zeroed");

   // Calendar and clock fields in range
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month != 5'd0
         && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59
         && (rsp_year_out_of_range || rsp_year_since_2000 <= 7'd99))
      else $error("result field out of range");

endmodule

bind unix_seconds_to_date_unit ustd_checker u_ustd_checker (.*);

// File: tb/calendar_check_pkg.sv
`timescale 1ns / 100ps
// Calendar scoreboard for the seconds-to-date converter: predicts each date and checks results.
// Depends on ustd_pkg for the result record.

package calendar_check_pkg;
   import ustd_pkg::*;

   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned SECONDS_PER_HOUR   = 3600;
   localparam int unsigned SECONDS_PER_DAY    = 86400;
   localparam int unsigned HOURS_PER_DAY      = 24;
   localparam int unsigned MINUTES_PER_HOUR   = 60;
   localparam int unsigned EPOCH_YEAR         = 1970;
   localparam int unsigned FIRST_YEAR         = 2000;
   localparam int unsigned LAST_YEAR          = 2099;
   localparam int unsigned FEBRUARY           = 1;
   localparam int unsigned DECEMBER           = 11;
   localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   class calendar_checker;
      result_type  pending_dates[$];
      int unsigned error_count;

      // Gregorian rule: every 4th year, not every 100th, but every 400th
      function bit leap_year(int unsigned yr);
         return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      endfunction

      function result_type date_from_seconds(logic [31:0] ts);
         result_type  d;
         int unsigned days_left;
         int unsigned yr;
         int unsigned mon_idx;
         int unsigned mon_len;
         d.second = 6'(ts % SECONDS_PER_MINUTE);
         d.minute = 6'((ts / SECONDS_PER_MINUTE) % MINUTES_PER_HOUR);
         d.hour   = 5'((ts / SECONDS_PER_HOUR) % HOURS_PER_DAY);
         days_left = ts / SECONDS_PER_DAY;

         // peel off whole years from the epoch
         yr = EPOCH_YEAR;
         while (days_left >= 365 + int'(leap_year(yr))) begin
            days_left -= 365 + int'(leap_year(yr));
            yr++;
         end

         // then whole months, December takes whatever is left
         mon_idx = 0;
         while (mon_idx < DECEMBER) begin
            mon_len = DAYS_IN_MONTH[mon_idx];
            if (mon_idx == FEBRUARY && leap_year(yr))
               mon_len++;
            if (days_left < mon_len)
               break;
            days_left -= mon_len;
            mon_idx++;
         end

         d.month        = 4'(mon_idx + 1);
         d.day_of_month = 5'(days_left + 1);
         d.year_out_of_range = (yr < FIRST_YEAR) || (yr > LAST_YEAR);
         d.year_since_2000   = d.year_out_of_range ? 7'd0 : 7'(yr - FIRST_YEAR);
         return d;
      endfunction

      function void note_timestamp(logic [31:0] ts);
         pending_dates.push_back(date_from_seconds(ts));
      endfunction

      function void check_field(string field_name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field_name, want, got);
            error_count++;
         end
      endfunction

      function void check_date(result_type got);
         result_type want;
         if (pending_dates.size() == 0) begin
            $error("result item arrived with no timestamp outstanding");
            error_count++;
            return;
         end
         want = pending_dates.pop_front();
         check_field("year_since_2000", want.year_since_2000, got.year_since_2000);
         check_field("month", want.month, got.month);
         check_field("day_of_month", want.day_of_month, got.day_of_month);
         check_field("hour", want.hour, got.hour);
         check_field("minute", want.minute, got.minute);
         check_field("second", want.second, got.second);
         check_field("year_out_of_range", want.year_out_of_range, got.year_out_of_range);
      endfunction
   endclass

endpackage

// File: tb/tb_unix_seconds_to_date_unit.sv
`timescale 1ns / 100ps
// Testbench for unix_seconds_to_date_unit: landmark dates, then random timestamps with stalls.
// Depends on ustd_pkg, calendar_check_pkg and the converter RTL.

module tb_unix_seconds_to_date_unit;
   import ustd_pkg::*;
   import calendar_check_pkg::*;

   localparam int RANDOM_ITEMS  = 1830;
   localparam int QUIET_TAIL    = 200;
   localparam int DRAIN_CYCLES  = 250;
   localparam int CYCLE_LIMIT   = 2_500_000;
   localparam int LAST_DAY      = 49710;

   // Calendar landmarks: epoch, year and month edges, leap days, top of range
   localparam logic [31:0] LANDMARKS [23] = '{
      32'd0,            // 1970-01-01 00:00:00
      32'd86399,        // end of first day
      32'd86400,
      32'd31535999,     // 1970-12-31 23:59:59
      32'd68169600,     // 1972-02-29
      32'd946684799,    // last second before 2000
      32'd946684800,    // 2000-01-01
      32'd951782400,    // 2000-02-29, century leap year
      32'd951868800,    // 2000-03-01
      32'd978220800,    // 2000-12-31
      32'd978307200,    // 2001-01-01
      32'd1000000000,
      32'd1078012800,   // 2004-02-29
      32'h7FFFFFFF,
      32'h80000000,
      32'h55555555,
      32'hAAAAAAAA,
      32'd4102444799,   // 2099-12-31 23:59:59
      32'd4102444800,   // 2100-01-01, first flagged year
      32'd4107456000,   // 2100-02-28, century non-leap
      32'd4107542400,   // 2100-03-01
      32'd4294944000,   // last whole day
      32'hFFFFFFFF      // 2106-02-07 06:28:15
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_year_since_2000;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic        rsp_year_out_of_range;

   result_type      rsp_date;
   calendar_checker dates;
   bit              idling = 1'b0;
   int              stall_left = 0;
   int unsigned     cycle_count = 0;

   unix_seconds_to_date_unit DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_timestamp         (req_timestamp),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_year_since_2000   (rsp_year_since_2000),
      .rsp_month             (rsp_month),
      .rsp_day_of_month      (rsp_day_of_month),
      .rsp_hour              (rsp_hour),
      .rsp_minute            (rsp_minute),
      .rsp_second            (rsp_second),
      .rsp_year_out_of_range (rsp_year_out_of_range)
   );

   assign rsp_date = '{rsp_year_since_2000, rsp_month, rsp_day_of_month, rsp_hour,
                       rsp_minute, rsp_second, rsp_year_out_of_range};

   initial begin
      forever #5 clock = ~clock;
   end

   // Present one timestamp, optionally after a short gap, and hold it until taken
   task automatic send_timestamp(input logic [31:0] ts, input bit allow_gap);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_timestamp <= ts;
      do @(posedge clock); while (req_stall);
      dates.note_timestamp(ts);
   endtask

   // Stimulus: landmarks first, then a mix of random timestamps
   initial begin
      longint unsigned near_edge;
      logic [31:0]     ts;
      bit              gaps;
      dates = new;
      repeat (8) @(posedge clock);
      reset  <= 1'b0;
      idling <= 1'b1;
      foreach (LANDMARKS[i])
         send_timestamp(LANDMARKS[i], 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 2))
            0: ts = $urandom;
            1: ts = $urandom_range(946684800, 4102444799);   // inside 2000..2099
            default: begin
               // just after or just before a midnight, hits month and year edges
               near_edge = longint'($urandom_range(0, LAST_DAY)) * SECONDS_PER_DAY;
               if ($urandom_range(0, 1) == 0)
                  near_edge += $urandom_range(0, 2);
               else
                  near_edge += SECONDS_PER_DAY - 1 - $urandom_range(0, 2);
               ts = (near_edge > 64'hFFFFFFFF) ? 32'hFFFFFFFF : near_edge[31:0];
            end
         endcase
         gaps = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 120) % 4 != 3);
         idling <= gaps;
         send_timestamp(ts, gaps);
      end
      req_valid <= 1'b0;

      while (dates.pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (dates.error_count == 0 && dates.pending_dates.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Result side: check accepted items, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         dates.check_date(rsp_date);
      if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
